[design/i2cw_pkg.sv]
package i2cw_pkg;

    // Field widths of the stream items and configuration registers.
    localparam int ADDR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int HALF_W  = 10;
    localparam int GUARD_W = 16;
    localparam int BITS_W  = 4;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 8;

    // Depth of the queue between the front and the engine.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Reset values of the configuration registers.
    localparam logic [HALF_W-1:0]  HALF_RESET  = HALF_W'(5);
    localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(1000);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_HALF  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_GUARD = IDX_W'(1);

    // Function codes carried on the input stream.
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_BEGIN   = 2'd1;
    localparam logic [1:0] FUNC_DATA    = 2'd2;
    localparam logic [1:0] FUNC_RECOVER = 2'd3;

    // Status codes reported with every result.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_NACK    = 2'd3;

    // Last data bit index, the acknowledge clock and the recovery pulse limit.
    localparam logic [BITS_W-1:0] LAST_DATA_BIT = BITS_W'(7);
    localparam logic [BITS_W-1:0] ACK_BIT       = BITS_W'(8);
    localparam logic [BITS_W-1:0] RECOVER_MAX   = BITS_W'(9);

    // Command class decoded by the front.
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_BEGIN   = 2'd1,
        CMD_DATA    = 2'd2,
        CMD_RECOVER = 2'd3
    } cmd_t;

    // One classified tick as it travels through the queue.
    typedef struct packed {
        logic              scl;
        logic              sda;
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              last;
    } item_t;

    // Bus sequencer phases.
    typedef enum logic [16:0] {
        PH_IDLE     = 17'h00001,
        PH_ST_WAIT  = 17'h00002,
        PH_ST_H1    = 17'h00004,
        PH_ST_H2    = 17'h00008,
        PH_B_LOW    = 17'h00010,
        PH_B_WAIT   = 17'h00020,
        PH_B_HIGH   = 17'h00040,
        PH_HOLD     = 17'h00080,
        PH_SP_1     = 17'h00100,
        PH_SP_WAIT  = 17'h00200,
        PH_SP_2     = 17'h00400,
        PH_SP_3     = 17'h00800,
        PH_RC_0     = 17'h01000,
        PH_RC_WAIT  = 17'h02000,
        PH_RC_LOW   = 17'h04000,
        PH_RC_SWAIT = 17'h08000,
        PH_RC_HIGH  = 17'h10000
    } phase_t;

endpackage

[design/i2c_master_write_engine.sv]
// Write-only I2C master with clock-stretch tolerance. Every input transfer is one
// time tick carrying the sampled SCL and SDA levels and an optional command, and
// yields exactly one result transfer with the open-drain pull-low requests, the
// ready and done flags and the status. One tick is taken every clock cycle unless
// the output stalls: the bus sequencer performs one step per cycle, and a one-entry
// input register plus a four-entry queue decouple intake from the sequencer. A tick
// passes the input register, queue and result register. Configuration (half period,
// stretch guard) is written through the plain write port, by the user only while no
// transfer is in flight; the block itself does not enforce this.
module i2c_master_write_engine
    import i2cw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    // scl_in, sda_in, target_addr, data_byte, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    // func
    input  logic [1:0]       s_tuser,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    // scl_pull_low, sda_pull_low, ready_res, done_res, status, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    logic  push;
    item_t push_item;
    logic  q_ready;
    logic  q_valid;
    item_t q_item;
    logic  pop;

    // Intake and command classification.
    i2cw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready)
    );

    // Tick queue.
    i2cw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    // Bus sequencer and result register.
    i2cw_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[design/i2cw_front.sv]
module i2cw_front
    import i2cw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    // scl_in, sda_in, target_addr, data_byte, zero fill
    input  logic [IN_W-1:0] s_tdata,
    // func
    input  logic [1:0]      s_tuser,
    input  logic            s_tlast,
    output logic            push,
    output item_t           push_item,
    input  logic            q_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    cmd_t  cmd;
    logic  load;

    // Classify the function code.
    always_comb
    begin
        unique case (s_tuser)
            FUNC_TICK:    cmd = CMD_TICK;
            FUNC_BEGIN:   cmd = CMD_BEGIN;
            FUNC_DATA:    cmd = CMD_DATA;
            FUNC_RECOVER: cmd = CMD_RECOVER;
            default:      cmd = CMD_TICK;
        endcase
    end

    // The input stage takes a new transfer whenever it is empty or draining.
    assign s_tready  = !valid_reg || q_ready;
    assign load      = s_tvalid && s_tready;
    assign push      = valid_reg && q_ready;
    assign push_item = item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each accepted transfer.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.scl  <= s_tdata[0];
            item_reg.sda  <= s_tdata[1];
            item_reg.cmd  <= cmd;
            item_reg.addr <= s_tdata[2 +: ADDR_W];
            item_reg.data <= s_tdata[2 + ADDR_W +: BYTE_W];
            item_reg.last <= s_tlast;
        end
    end

endmodule

[design/i2cw_queue.sv]
module i2cw_queue
    import i2cw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  q_ready,
    output logic  q_valid,
    output item_t q_item,
    input  logic  pop
);

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_ready = count_reg != QCNT_W'(QDEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = mem[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n)
        !q_ready |-> !push;
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("queue written while full");

endmodule

[design/i2cw_engine.sv]
module i2cw_engine
    import i2cw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    // scl_pull_low, sda_pull_low, ready_res, done_res, status, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    logic [HALF_W-1:0]  half_reg;
    logic [GUARD_W-1:0] guard_reg;

    phase_t             phase_reg,   phase_next;
    logic [BYTE_W-1:0]  shift_reg,   shift_next;
    logic [BITS_W-1:0]  bits_reg,    bits_next;
    logic [HALF_W-1:0]  htimer_reg,  htimer_next;
    logic [GUARD_W-1:0] gtimer_reg,  gtimer_next;
    logic [BITS_W-1:0]  rcount_reg,  rcount_next;
    logic [BYTE_W-1:0]  pending_reg, pending_next;
    logic               stop_reg,    stop_next;
    logic [1:0]         err_reg,     err_next;
    logic               scl_reg,     scl_next;
    logic               sda_reg,     sda_next;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic               done;
    logic               ready_now;
    logic               delay_end;
    logic               guard_zero;
    logic [BITS_W-1:0]  rcount_inc;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= HALF_RESET;
            guard_reg <= GUARD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_HALF)
            begin
                half_reg <= cfg_data[HALF_W-1:0];
            end
            else if (cfg_index == REG_GUARD)
            begin
                guard_reg <= cfg_data[GUARD_W-1:0];
            end
        end
    end

    // One tick is taken whenever the result register is free or draining.
    assign pop = q_valid && (!out_valid_reg || m_tready);

    assign delay_end  = htimer_reg <= HALF_W'(1);
    assign guard_zero = gtimer_reg == '0;
    assign rcount_inc = rcount_reg + BITS_W'(1);

    // Bus sequencer: one step per tick.
    always_comb
    begin
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        htimer_next  = htimer_reg;
        gtimer_next  = gtimer_reg;
        rcount_next  = rcount_reg;
        pending_next = pending_reg;
        stop_next    = stop_reg;
        err_next     = err_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        done         = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (q_item.cmd == CMD_BEGIN)
                begin
                    err_next     = ST_OK;
                    shift_next   = {q_item.addr, 1'b0};
                    pending_next = q_item.data;
                    stop_next    = q_item.last;
                    rcount_next  = BITS_W'(1);
                    scl_next     = 1'b0;
                    sda_next     = 1'b0;
                    gtimer_next  = guard_reg;
                    phase_next   = PH_ST_WAIT;
                end
                else if (q_item.cmd == CMD_RECOVER)
                begin
                    err_next    = ST_OK;
                    rcount_next = '0;
                    scl_next    = 1'b0;
                    sda_next    = 1'b0;
                    htimer_next = half_reg;
                    phase_next  = PH_RC_0;
                end
            end

            PH_ST_WAIT:
            begin
                if (q_item.scl)
                begin
                    htimer_next = half_reg;
                    phase_next  = PH_ST_H1;
                end
                else if (guard_zero)
                begin
                    err_next    = ST_TIMEOUT;
                    sda_next    = 1'b1;
                    htimer_next = half_reg;
                    phase_next  = PH_SP_1;
                end
                else
                begin
                    gtimer_next = gtimer_reg - GUARD_W'(1);
                end
            end

            PH_ST_H1:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else if (!q_item.sda)
                begin
                    err_next    = ST_BUSY;
                    sda_next    = 1'b1;
                    htimer_next = half_reg;
                    phase_next  = PH_SP_1;
                end
                else
                begin
                    sda_next    = 1'b1;
                    htimer_next = half_reg;
                    phase_next  = PH_ST_H2;
                end
            end

            PH_ST_H2:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else
                begin
                    scl_next    = 1'b1;
                    bits_next   = '0;
                    sda_next    = !shift_reg[BYTE_W-1];
                    htimer_next = half_reg;
                    phase_next  = PH_B_LOW;
                end
            end

            PH_B_LOW:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else
                begin
                    scl_next    = 1'b0;
                    gtimer_next = guard_reg;
                    phase_next  = PH_B_WAIT;
                end
            end

            PH_B_WAIT:
            begin
                if (q_item.scl)
                begin
                    htimer_next = half_reg;
                    phase_next  = PH_B_HIGH;
                end
                else if (guard_zero)
                begin
                    scl_next    = 1'b1;
                    err_next    = ST_TIMEOUT;
                    sda_next    = 1'b1;
                    htimer_next = half_reg;
                    phase_next  = PH_SP_1;
                end
                else
                begin
                    gtimer_next = gtimer_reg - GUARD_W'(1);
                end
            end

            PH_B_HIGH:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else
                begin
                    scl_next = 1'b1;
                    priority if (bits_reg < ACK_BIT)
                    begin
                        // Next data bit, or release SDA for the acknowledge clock.
                        shift_next  = {shift_reg[BYTE_W-2:0], 1'b0};
                        bits_next   = bits_reg + BITS_W'(1);
                        sda_next    = (bits_reg == LAST_DATA_BIT) ?
                                      1'b0 : !shift_reg[BYTE_W-2];
                        htimer_next = half_reg;
                        phase_next  = PH_B_LOW;
                    end
                    else if (q_item.sda)
                    begin
                        err_next    = ST_NACK;
                        sda_next    = 1'b1;
                        htimer_next = half_reg;
                        phase_next  = PH_SP_1;
                    end
                    else if (rcount_reg == BITS_W'(1))
                    begin
                        // Address acknowledged: the control byte follows.
                        rcount_next = '0;
                        shift_next  = pending_reg;
                        bits_next   = '0;
                        sda_next    = !pending_reg[BYTE_W-1];
                        htimer_next = half_reg;
                        phase_next  = PH_B_LOW;
                    end
                    else if (stop_reg)
                    begin
                        sda_next    = 1'b1;
                        htimer_next = half_reg;
                        phase_next  = PH_SP_1;
                    end
                    else
                    begin
                        done       = 1'b1;
                        phase_next = PH_HOLD;
                    end
                end
            end

            PH_HOLD:
            begin
                if (q_item.cmd == CMD_DATA)
                begin
                    stop_next   = q_item.last;
                    shift_next  = q_item.data;
                    bits_next   = '0;
                    sda_next    = !q_item.data[BYTE_W-1];
                    htimer_next = half_reg;
                    phase_next  = PH_B_LOW;
                end
            end

            PH_SP_1:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else
                begin
                    scl_next    = 1'b0;
                    gtimer_next = guard_reg;
                    phase_next  = PH_SP_WAIT;
                end
            end

            PH_SP_WAIT:
            begin
                // A timeout here lets the STOP go on.
                if (q_item.scl || guard_zero)
                begin
                    htimer_next = half_reg;
                    phase_next  = PH_SP_2;
                end
                else
                begin
                    gtimer_next = gtimer_reg - GUARD_W'(1);
                end
            end

            PH_SP_2:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else
                begin
                    sda_next    = 1'b0;
                    htimer_next = half_reg;
                    phase_next  = PH_SP_3;
                end
            end

            PH_SP_3:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end

            PH_RC_0:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else if (!q_item.sda)
                begin
                    gtimer_next = guard_reg;
                    phase_next  = PH_RC_WAIT;
                end
                else
                begin
                    sda_next    = 1'b1;
                    htimer_next = half_reg;
                    phase_next  = PH_SP_1;
                end
            end

            PH_RC_WAIT:
            begin
                if (q_item.scl)
                begin
                    rcount_next = '0;
                    scl_next    = 1'b1;
                    htimer_next = half_reg;
                    phase_next  = PH_RC_LOW;
                end
                else if (guard_zero)
                begin
                    sda_next    = 1'b1;
                    htimer_next = half_reg;
                    phase_next  = PH_SP_1;
                end
                else
                begin
                    gtimer_next = gtimer_reg - GUARD_W'(1);
                end
            end

            PH_RC_LOW:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else
                begin
                    scl_next    = 1'b0;
                    gtimer_next = guard_reg;
                    phase_next  = PH_RC_SWAIT;
                end
            end

            PH_RC_SWAIT:
            begin
                if (q_item.scl || guard_zero)
                begin
                    htimer_next = half_reg;
                    phase_next  = PH_RC_HIGH;
                end
                else
                begin
                    gtimer_next = gtimer_reg - GUARD_W'(1);
                end
            end

            PH_RC_HIGH:
            begin
                if (!delay_end)
                begin
                    htimer_next = htimer_reg - HALF_W'(1);
                end
                else
                begin
                    rcount_next = rcount_inc;
                    if (q_item.sda || (rcount_inc >= RECOVER_MAX))
                    begin
                        sda_next    = 1'b1;
                        htimer_next = half_reg;
                        phase_next  = PH_SP_1;
                    end
                    else
                    begin
                        scl_next    = 1'b1;
                        htimer_next = half_reg;
                        phase_next  = PH_RC_LOW;
                    end
                end
            end

            default:
            begin
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign ready_now = (phase_next == PH_IDLE) || (phase_next == PH_HOLD);

    // Sequencer state advances only on a consumed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            shift_reg   <= '0;
            bits_reg    <= '0;
            htimer_reg  <= '0;
            gtimer_reg  <= '0;
            rcount_reg  <= '0;
            pending_reg <= '0;
            stop_reg    <= 1'b0;
            err_reg     <= ST_OK;
            scl_reg     <= 1'b0;
            sda_reg     <= 1'b0;
        end
        else if (pop)
        begin
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            htimer_reg  <= htimer_next;
            gtimer_reg  <= gtimer_next;
            rcount_reg  <= rcount_next;
            pending_reg <= pending_next;
            stop_reg    <= stop_next;
            err_reg     <= err_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

    // Result register toward the output stream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {2'b00, err_next, done, ready_now, sda_next, scl_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A completion is always reported with the engine ready for a command.
    property p_done_ready;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2];
    endproperty
    a_done_ready: assert property (p_done_ready)
        else $error("done reported while engine busy");

    // Between bytes the clock line stays held low.
    property p_hold_scl;
        @(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HOLD |-> scl_reg;
    endproperty
    a_hold_scl: assert property (p_hold_scl)
        else $error("SCL released while holding between bytes");

    // The bit counter never passes the acknowledge clock.
    property p_bits_range;
        @(posedge clk) disable iff (!rst_n)
        bits_reg <= ACK_BIT;
    endproperty
    a_bits_range: assert property (p_bits_range)
        else $error("bit counter out of range");

    // A stalled result is not overwritten.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result changed");

endmodule
